[src/lps_pkg.sv]
package lps_pkg;

  // sizes
  localparam int MAX_MESSAGE = 32;
  localparam int CNT_W       = $clog2(MAX_MESSAGE + 1);
  localparam int HASH_W      = 31;
  localparam int SEED_W      = 30;
  localparam int QUOT_W      = 5;

  localparam logic [CNT_W-1:0]  MAX_CNT     = CNT_W'(MAX_MESSAGE);
  localparam logic [HASH_W-1:0] MIX_INIT    = 31'd1345345333;
  localparam logic [HASH_W-1:0] ACCUM_INIT  = 31'h12345671;
  localparam logic [HASH_W-1:0] ADDEND_INIT = 31'd7;
  localparam logic [SEED_W-1:0] SEED_MOD    = 30'h3fffffff;
  localparam logic [5:0]        SEED_INC    = 6'd33;
  localparam logic [6:0]        OUT_OFFSET  = 7'd64;
  localparam logic [7:0]        CHAR_SPACE  = 8'h20;
  localparam logic [7:0]        CHAR_TAB    = 8'h09;

  typedef enum logic [1:0] {
    CMD_CHALLENGE = 2'd0,
    CMD_PASSWORD  = 2'd1,
    CMD_FINISH    = 2'd2
  } lps_cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_byte;
  } lps_req_t;

  typedef struct packed {
    logic [6:0] out_byte;
    logic       last;
    logic       empty_message;
    logic       overflow;
  } lps_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic absorb;
    logic save_hash;
    logic count_byte;
    logic seed_init;
    logic seed_step;
    logic extra_load;
    logic emit;
    logic clear_all;
  } lps_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic phase_pw;
    logic empty;
    logic steps_eq;
    logic out_free;
  } lps_sts_t;

endpackage

[src/lps_datapath.sv]
module lps_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        char_byte_i,
  input  lps_pkg::lps_ctl_t ctl_i,
  output lps_pkg::lps_sts_t sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output lps_pkg::lps_rsp_t out_rsp_o
);
  import lps_pkg::*;

  // fold mod 2^30-1, input below 2^33
  function automatic logic [SEED_W-1:0] seed_red(input logic [32:0] x);
    logic [30:0] f;
    f = 31'(x[29:0]) + 31'(x[32:30]);
    if (f >= 31'(SEED_MOD)) begin
      f = f - 31'(SEED_MOD);
    end
    return f[SEED_W-1:0];
  endfunction

  // s / 34636833 == floor(s * 31 / (2^30 - 1))
  function automatic logic [QUOT_W-1:0] seed_quot(input logic [SEED_W-1:0] s);
    logic [34:0]       y;
    logic [QUOT_W-1:0] q0;
    logic [30:0]       r;
    y  = {s, 5'b0} - 35'(s);
    q0 = y[34:30];
    r  = 31'(y[29:0]) + 31'(q0);
    return (r >= 31'(SEED_MOD)) ? q0 + 5'd1 : q0;
  endfunction

  logic [HASH_W-1:0] mix_q, mix_d, accum_q, accum_d, addend_q, addend_d;
  logic [HASH_W-1:0] ch_lo_q, ch_lo_d, ch_hi_q, ch_hi_d;
  logic [CNT_W-1:0]  count_q, count_d, step_q, step_d;
  logic              phase_q, phase_d, ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic [SEED_W-1:0] seed1_q, seed1_d, seed2_q, seed2_d;
  logic [SEED_W-1:0] init1_q, init1_d, init2_q, init2_d;
  logic [QUOT_W-1:0] extra_q, extra_d;
  lps_rsp_t          out_q, out_d;

  logic [HASH_W-1:0] base_mix, base_accum, base_addend, mix_term, mix_new;
  logic              is_blank;
  logic [32:0]       t1, t2;
  logic [SEED_W-1:0] s1_next, s2_next, s1_init, s2_init;
  logic [QUOT_W-1:0] quot;

  always_comb begin
    // hash restart on save or clear
    if (ctl_i.save_hash || ctl_i.clear_all) begin
      base_mix    = MIX_INIT;
      base_accum  = ACCUM_INIT;
      base_addend = ADDEND_INIT;
    end else begin
      base_mix    = mix_q;
      base_accum  = accum_q;
      base_addend = addend_q;
    end
    is_blank = (char_byte_i == CHAR_SPACE) || (char_byte_i == CHAR_TAB);
    mix_term = HASH_W'((HASH_W'(base_mix[5:0]) + base_addend) * HASH_W'(char_byte_i))
               + (base_mix << 8);
    mix_new  = base_mix ^ mix_term;

    mix_d    = base_mix;
    accum_d  = base_accum;
    addend_d = base_addend;
    if (ctl_i.absorb && !is_blank) begin
      mix_d    = mix_new;
      accum_d  = base_accum + ((base_accum << 8) ^ mix_new);
      addend_d = base_addend + HASH_W'(char_byte_i);
    end

    ch_lo_d = ch_lo_q;
    ch_hi_d = ch_hi_q;
    phase_d = phase_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (ctl_i.save_hash) begin
      ch_lo_d = mix_q;
      ch_hi_d = accum_q;
      phase_d = 1'b1;
    end
    if (ctl_i.count_byte) begin
      if (count_q < MAX_CNT) begin
        count_d = count_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (ctl_i.clear_all) begin
      ch_lo_d = '0;
      ch_hi_d = '0;
      phase_d = 1'b0;
      count_d = '0;
      ovf_d   = 1'b0;
    end

    // generator step
    t1      = 33'({seed1_q, 1'b0}) + 33'(seed1_q) + 33'(seed2_q);
    s1_next = seed_red(t1);
    t2      = 33'(s1_next) + 33'(seed2_q) + 33'(SEED_INC);
    s2_next = seed_red(t2);
    s1_init = seed_red(33'(mix_q ^ ch_lo_q));
    s2_init = seed_red(33'(accum_q ^ ch_hi_q));
    quot    = seed_quot(seed1_q);

    seed1_d = seed1_q;
    seed2_d = seed2_q;
    init1_d = init1_q;
    init2_d = init2_q;
    extra_d = extra_q;
    step_d  = step_q;
    if (ctl_i.seed_init) begin
      seed1_d = s1_init;
      seed2_d = s2_init;
      init1_d = s1_init;
      init2_d = s2_init;
      step_d  = '0;
    end else if (ctl_i.seed_step) begin
      seed1_d = s1_next;
      seed2_d = s2_next;
      step_d  = step_q + 1'b1;
    end else if (ctl_i.extra_load) begin
      extra_d = quot;
      seed1_d = init1_q;
      seed2_d = init2_q;
      step_d  = '0;
    end

    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (ctl_i.emit) begin
      out_valid_d           = 1'b1;
      out_d.empty_message   = (count_q == '0);
      out_d.last            = (step_q == count_q);
      out_d.overflow        = ovf_q;
      out_d.out_byte        = (count_q == '0) ? 7'd0 : OUT_OFFSET + 7'(quot ^ extra_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q       <= MIX_INIT;
      accum_q     <= ACCUM_INIT;
      addend_q    <= ADDEND_INIT;
      ch_lo_q     <= '0;
      ch_hi_q     <= '0;
      phase_q     <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mix_q       <= mix_d;
      accum_q     <= accum_d;
      addend_q    <= addend_d;
      ch_lo_q     <= ch_lo_d;
      ch_hi_q     <= ch_hi_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed1_q <= seed1_d;
    seed2_q <= seed2_d;
    init1_q <= init1_d;
    init2_q <= init2_d;
    extra_q <= extra_d;
    out_q   <= out_d;
  end

  assign sts_o.phase_pw = phase_q;
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.steps_eq = (step_q == count_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("challenge count above limit");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == MAX_CNT))
    else $error("overflow flag with count below limit");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites a pending result");

  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear_all |=> (count_q == '0) && !phase_q && !ovf_q)
    else $error("run state not cleared after finish");

  a_last_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.emit && !ctl_i.clear_all) |-> (step_q < count_q))
    else $error("non-final result past challenge length");

endmodule

[src/lps_ctrl.sv]
module lps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_cmd_i,
  input  lps_pkg::lps_sts_t sts_i,
  output lps_pkg::lps_ctl_t ctl_o
);
  import lps_pkg::*;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_SEED,
    ST_SPIN,
    ST_EXTRA,
    ST_STEP,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_COLLECT: begin
        if (in_valid_i) begin
          case (in_cmd_i)
            CMD_CHALLENGE: begin
              if (!sts_i.phase_pw) begin
                ctl_o.absorb     = 1'b1;
                ctl_o.count_byte = 1'b1;
              end
            end
            CMD_PASSWORD: begin
              ctl_o.absorb    = 1'b1;
              ctl_o.save_hash = !sts_i.phase_pw;
            end
            CMD_FINISH: begin
              ctl_o.save_hash = !sts_i.phase_pw;
              state_d         = ST_SEED;
            end
            default: ;
          endcase
        end
      end
      ST_SEED: begin
        ctl_o.seed_init = 1'b1;
        state_d         = sts_i.empty ? ST_OUT : ST_SPIN;
      end
      ST_SPIN: begin
        // n + 1 steps to reach the mask seed
        ctl_o.seed_step = 1'b1;
        if (sts_i.steps_eq) begin
          state_d = ST_EXTRA;
        end
      end
      ST_EXTRA: begin
        ctl_o.extra_load = 1'b1;
        state_d          = ST_STEP;
      end
      ST_STEP: begin
        ctl_o.seed_step = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          if (sts_i.steps_eq) begin
            ctl_o.clear_all = 1'b1;
            state_d         = ST_COLLECT;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_COLLECT);

endmodule

[src/legacy_password_scramble.sv]
// legacy challenge scramble (old pre-4.1 password scheme): send challenge bytes
// (command 0), then password bytes (command 1), then a finish request (command 2).
// each string is hashed with the classic mix/accum/addend hash, spaces and tabs
// skipped, and kept to 31 bits. challenge and password bytes are taken whenever
// in_ready_o is high. a finish request starts a generator seeded from the xor of
// both hashes; it produces one 7-bit result per challenge byte (whitespace counted,
// at most MAX_MESSAGE; longer challenges set overflow on every result). the single
// step unit runs the generator twice, once n+1 steps to find the mask and once n
// steps to emit, so a finish with n challenge bytes keeps the input side busy
// through the seed load, the mask steps, the mask load, then a step and an emit
// per result (only the seed load and the emit for an empty challenge), and stays
// busy while the output side holds off ready. an empty challenge gives a single
// result flagged empty_message. no request is taken while a finish is in progress;
// the block clears its hash, count and overflow state and returns to collecting
// after the last result is handed to the output register, and may take the next
// request while that result still waits to be taken.
module legacy_password_scramble (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lps_pkg::lps_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lps_pkg::lps_rsp_t out_rsp_o
);
  import lps_pkg::*;

  // command and status between sequencer and datapath
  lps_ctl_t ctl;
  lps_sts_t sts;

  // sequencer: collects requests, then walks the two generator passes
  lps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_cmd_i   (in_req_i.command),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // hash registers, seed step unit and output register
  lps_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_byte_i (in_req_i.char_byte),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
